// ===== hdl/block_pool_allocator_core_defines.svh =====
// Assertion macros shared by the block pool allocator RTL.
`ifndef BLOCK_POOL_ALLOCATOR_CORE_DEFINES_SVH
`define BLOCK_POOL_ALLOCATOR_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BPA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BPA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/bpa_pkg.sv =====
`default_nettype none

package bpa_pkg;

   localparam int unsigned IndexW = 8;
   localparam int unsigned CountW = 9;
   localparam int unsigned StatusW = 2;
   localparam int unsigned IndexSpan = 2 ** IndexW;
   localparam int unsigned DefaultPoolDepth = 256;

   localparam logic OpAlloc = 1'b0;
   localparam logic OpFree = 1'b1;

   localparam logic [StatusW-1:0] StatusOk = 2'd0;
   localparam logic [StatusW-1:0] StatusEmpty = 2'd1;
   localparam logic [StatusW-1:0] StatusRange = 2'd2;

   typedef struct packed {
      logic              en;
      logic [IndexW-1:0] addr;
      logic [IndexW-1:0] data;
   } bpa_wr_type;

endpackage

`default_nettype wire

// ===== hdl/bpa_link_ram.sv =====
`default_nettype none

module bpa_link_ram #(
   parameter int unsigned DEPTH = bpa_pkg::DefaultPoolDepth
) (
   input  wire                           clock,
   input  wire  bpa_pkg::bpa_wr_type     wr,
   input  wire                           rd_en,
   input  wire  [bpa_pkg::IndexW-1:0]    rd_addr,
   output logic [bpa_pkg::IndexW-1:0]    rd_data
);
   import bpa_pkg::*;

   localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [IndexW-1:0] link_mem [DEPTH];
   logic [IndexW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         link_mem[wr.addr[AddrW-1:0]] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= link_mem[rd_addr[AddrW-1:0]];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/block_pool_allocator_core.sv =====
`default_nettype none
`include "block_pool_allocator_core_defines.svh"

// Channel  Direction  Handshake           Transaction
// req      in         req_valid/req_stall opcode and block index
// rsp      out        rsp_valid/rsp_stall granted index, status, free count
// csr      in         csr_valid/csr_ready pool size, restarts the pool
//
// The link table read is issued when a request is accepted, and the update
// commits once the result register is empty or being drained.
// A new request is not taken until the one before it has committed.
// A stalled result holds the commit, so the request side stalls behind it.
// Reset is synchronous and leaves a full pool of the largest size; the link
// table needs no clearing pass.

module block_pool_allocator_core #(
   parameter int unsigned POOL_DEPTH = bpa_pkg::DefaultPoolDepth
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire                          req_opcode,
   input  wire  [bpa_pkg::IndexW-1:0]   req_block_index,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output logic [bpa_pkg::IndexW-1:0]   rsp_granted_index,
   output logic [bpa_pkg::StatusW-1:0]  rsp_status,
   output logic [bpa_pkg::CountW-1:0]   rsp_free_count,
   input  wire                          csr_valid,
   output logic                         csr_ready,
   input  wire  [bpa_pkg::CountW-1:0]   csr_blocks_in_use
);
   import bpa_pkg::*;

   localparam int unsigned CountTop = (POOL_DEPTH < IndexSpan) ? POOL_DEPTH : IndexSpan;
   localparam int unsigned MemDepth = CountTop;
   localparam logic [CountW-1:0] CountTopW = CountW'(CountTop);

   logic                busy_ff, busy_in;
   logic                op_ff, op_in;
   logic [IndexW-1:0]   idx_ff, idx_in;
   logic [CountW-1:0]   biu_ff, biu_in;
   logic [IndexW-1:0]   head_ff, head_in;
   logic                hv_ff, hv_in;
   logic [CountW-1:0]   ft_ff, ft_in;
   logic [CountW-1:0]   lp_ff, lp_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [IndexW-1:0]   granted_ff, granted_in;
   logic [StatusW-1:0]  status_ff, status_in;
   logic [CountW-1:0]   free_ff, free_in;

   logic                req_accept;
   logic                commit;
   logic                csr_write;
   logic                prep;
   logic                head_hit;
   logic                head_in_range;
   logic [CountW-1:0]   lp_plus1;
   logic [IndexW-1:0]   link_value;
   logic [IndexW-1:0]   rd_data;
   logic [CountW-1:0]   cap;
   bpa_wr_type          wr;

   bpa_link_ram #(
      .DEPTH (MemDepth)
   ) u_link_ram (
      .clock   (clock),
      .wr      (wr),
      .rd_en   (req_accept),
      .rd_addr (head_ff),
      .rd_data (rd_data)
   );

   assign req_stall = busy_ff;
   assign csr_ready = !busy_ff;
   assign req_accept = req_valid && !req_stall;
   assign csr_write = csr_valid && csr_ready;
   assign commit = busy_ff && (!rsp_valid_ff || !rsp_stall);

   assign prep = (op_ff == OpAlloc) && (lp_ff < biu_ff);
   assign lp_plus1 = lp_ff + CountW'(1);
   assign head_hit = prep && ({1'b0, head_ff} == lp_ff);
   assign head_in_range = 32'(head_ff) < POOL_DEPTH;

   // The link being prepared by this same allocate is not yet in the table.
   assign link_value = head_hit ? lp_plus1[IndexW-1:0] :
                       (head_in_range ? rd_data : '0);

   always_comb begin
      if (csr_blocks_in_use == '0) begin
         cap = CountW'(1);
      end else if (csr_blocks_in_use > CountTopW) begin
         cap = CountTopW;
      end else begin
         cap = csr_blocks_in_use;
      end
   end

   always_comb begin
      busy_in = busy_ff;
      op_in = op_ff;
      idx_in = idx_ff;
      biu_in = biu_ff;
      head_in = head_ff;
      hv_in = hv_ff;
      ft_in = ft_ff;
      lp_in = lp_ff;
      rsp_valid_in = rsp_valid_ff;
      granted_in = granted_ff;
      status_in = status_ff;
      free_in = free_ff;
      wr = '0;

      if (req_accept) begin
         busy_in = 1'b1;
         op_in = req_opcode;
         idx_in = req_block_index;
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (commit) begin
         busy_in = 1'b0;
         rsp_valid_in = 1'b1;
         granted_in = '0;
         status_in = StatusOk;
         if (op_ff == OpAlloc) begin
            if (prep) begin
               wr.en = 1'b1;
               wr.addr = lp_ff[IndexW-1:0];
               wr.data = lp_plus1[IndexW-1:0];
               lp_in = lp_plus1;
            end
            if (ft_ff != '0) begin
               granted_in = head_ff;
               ft_in = ft_ff - CountW'(1);
               if (ft_in != '0) begin
                  head_in = link_value;
               end else begin
                  hv_in = 1'b0;
               end
            end else begin
               status_in = StatusEmpty;
            end
         end else begin
            if ({1'b0, idx_ff} >= biu_ff) begin
               status_in = StatusRange;
            end else begin
               if (hv_ff) begin
                  wr.en = 1'b1;
                  wr.addr = idx_ff;
                  wr.data = head_ff;
               end
               head_in = idx_ff;
               hv_in = 1'b1;
               if (ft_ff != '1) begin
                  ft_in = ft_ff + CountW'(1);
               end
            end
         end
         free_in = ft_in;
      end

      if (csr_write) begin
         biu_in = cap;
         ft_in = cap;
         head_in = '0;
         hv_in = 1'b1;
         lp_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         biu_ff <= CountTopW;
         head_ff <= '0;
         hv_ff <= 1'b1;
         ft_ff <= CountTopW;
         lp_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         biu_ff <= biu_in;
         head_ff <= head_in;
         hv_ff <= hv_in;
         ft_ff <= ft_in;
         lp_ff <= lp_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      idx_ff <= idx_in;
      granted_ff <= granted_in;
      status_ff <= status_in;
      free_ff <= free_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_granted_index = granted_ff;
   assign rsp_status = status_ff;
   assign rsp_free_count = free_ff;

   `BPA_ASSERT_NOW(a_head_live, clock, reset, 1'b1, hv_ff == (ft_ff != '0), "head valid mismatch")
   `BPA_ASSERT_NOW(a_prep_bounded, clock, reset, 1'b1, lp_ff <= biu_ff, "links beyond pool size")
   `BPA_ASSERT_NEXT(a_commit, clock, reset, commit, !busy_ff && rsp_valid_ff, "commit lost")

endmodule

`default_nettype wire

// ===== tb/block_pool_allocator_core_test.sv =====
module block_pool_allocator_core_test;
   import bpa_pkg::*;

   localparam int unsigned PoolCap = DefaultPoolDepth;

   typedef struct packed {
      logic              opcode;
      logic [IndexW-1:0] block_index;
   } pool_op_type;

   typedef struct packed {
      logic [IndexW-1:0]  granted_index;
      logic [StatusW-1:0] status;
      logic [CountW-1:0]  free_count;
   } pool_grant_type;

   typedef struct packed {
      pool_op_type    op;
      pool_grant_type grant;
   } pool_job_type;

   typedef enum {PhaseMixed, PhaseDrain, PhaseFlood} phase_style_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_opcode = OpAlloc;
   logic [IndexW-1:0]   req_block_index = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [IndexW-1:0]   rsp_granted_index;
   logic [StatusW-1:0]  rsp_status;
   logic [CountW-1:0]   rsp_free_count;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [CountW-1:0]   csr_blocks_in_use = '0;

   logic [IndexW-1:0]   link_mem [PoolCap];
   bit                  link_known [PoolCap];
   logic [IndexW-1:0]   head_block;
   bit                  head_live;
   logic [CountW-1:0]   spare_count;
   logic [CountW-1:0]   links_built;
   logic [CountW-1:0]   pool_blocks;
   logic [IndexW-1:0]   owned_blocks [$];
   pool_job_type        pending_ops [$];
   pool_grant_type      expected_grants [$];
   int                  errors = 0;
   bit                  steady = 1'b0;

   block_pool_allocator_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_block_index   (req_block_index),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_granted_index (rsp_granted_index),
      .rsp_status        (rsp_status),
      .rsp_free_count    (rsp_free_count),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_blocks_in_use (csr_blocks_in_use)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic void restart_pool();
      spare_count = pool_blocks;
      head_block = '0;
      head_live = 1'b1;
      links_built = '0;
      owned_blocks.delete();
   endfunction

   function automatic pool_grant_type predict_grant(pool_op_type op);
      pool_grant_type g;
      g.granted_index = '0;
      g.status = StatusOk;
      if (op.opcode == OpAlloc) begin
         if (links_built < pool_blocks) begin
            link_mem[links_built[IndexW-1:0]] = links_built[IndexW-1:0] + 1'b1;
            link_known[links_built[IndexW-1:0]] = 1'b1;
            links_built = links_built + 1'b1;
         end
         if (spare_count != 0) begin
            g.granted_index = head_block;
            spare_count = spare_count - 1'b1;
            if (spare_count != 0) begin
               head_block = link_mem[head_block];
            end else begin
               head_live = 1'b0;
            end
         end else begin
            g.status = StatusEmpty;
         end
      end else if (op.block_index >= pool_blocks) begin
         g.status = StatusRange;
      end else begin
         if (head_live) begin
            link_mem[op.block_index] = head_block;
            link_known[op.block_index] = 1'b1;
         end
         head_block = op.block_index;
         head_live = 1'b1;
         if (spare_count != '1) begin
            spare_count = spare_count + 1'b1;
         end
      end
      g.free_count = spare_count;
      return g;
   endfunction

   // An allocate that would follow the free list into a link that was never
   // written is preceded by a free, so the list head always has a known link.
   function automatic void queue_op(logic opcode, logic [IndexW-1:0] idx);
      pool_op_type  op;
      pool_job_type job;
      if (opcode == OpAlloc && spare_count > 1 && !link_known[head_block] &&
          !(links_built < pool_blocks && links_built == head_block)) begin
         queue_op(OpFree, IndexW'($urandom_range(0, pool_blocks - 1)));
      end
      op.opcode = opcode;
      op.block_index = idx;
      job.op = op;
      job.grant = predict_grant(op);
      if (opcode == OpAlloc && job.grant.status == StatusOk) begin
         owned_blocks.push_back(job.grant.granted_index);
      end
      pending_ops.push_back(job);
   endfunction

   task automatic settle();
      while (pending_ops.size() != 0 || expected_grants.size() != 0) begin
         @(posedge clock);
      end
      repeat (3) @(posedge clock);
   endtask

   task automatic run_phase(logic [CountW-1:0] setting, int count, phase_style_type style,
                            bit calm);
      int                roll;
      int                pick;
      logic [IndexW-1:0] idx;
      settle();
      steady = calm;
      csr_blocks_in_use <= setting;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      pool_blocks = (setting == 0) ? CountW'(1) :
                    (setting > PoolCap) ? CountW'(PoolCap) : setting;
      restart_pool();
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(0, 99);
         if (style == PhaseDrain && n < pool_blocks + 4) begin
            queue_op(OpAlloc, IndexW'($urandom_range(0, 255)));
         end else if (style == PhaseFlood && n < count - 30) begin
            queue_op(OpFree, IndexW'($urandom_range(0, 255)));
         end else if (roll < 45 || (roll < 80 && owned_blocks.size() == 0)) begin
            queue_op(OpAlloc, IndexW'($urandom_range(0, 255)));
         end else if (roll < 80) begin
            pick = $urandom_range(0, owned_blocks.size() - 1);
            idx = owned_blocks[pick];
            owned_blocks.delete(pick);
            queue_op(OpFree, idx);
         end else begin
            queue_op(OpFree, IndexW'($urandom_range(0, 255)));
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && req_stall)) begin
         if (req_valid) begin
            expected_grants.push_back(pending_ops[0].grant);
            pending_ops.delete(0);
         end
         if (pending_ops.size() != 0 && (steady || $urandom_range(0, 99) >= 24)) begin
            req_valid <= 1'b1;
            req_opcode <= pending_ops[0].op.opcode;
            req_block_index <= pending_ops[0].op.block_index;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : watch_rsp
      pool_grant_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_grants.size() == 0) begin
               errors++;
               if (errors <= 10) begin
                  $display("unexpected transaction: index %0d status %0d count %0d",
                           rsp_granted_index, rsp_status, rsp_free_count);
               end
            end else begin
               want = expected_grants.pop_front();
               if (rsp_granted_index !== want.granted_index || rsp_status !== want.status ||
                   rsp_free_count !== want.free_count) begin
                  errors++;
                  if (errors <= 10) begin
                     $display("mismatch: expected index %0d status %0d count %0d, got %0d %0d %0d",
                              want.granted_index, want.status, want.free_count,
                              rsp_granted_index, rsp_status, rsp_free_count);
                  end
               end
            end
         end
         rsp_stall <= !steady && ($urandom_range(0, 99) < 24);
      end
   end

   initial begin
      pool_blocks = CountW'(PoolCap);
      restart_pool();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      queue_op(OpAlloc, 8'd255);
      queue_op(OpAlloc, 8'd0);
      queue_op(OpFree, 8'd1);
      queue_op(OpFree, 8'd1);
      queue_op(OpFree, 8'd255);
      queue_op(OpAlloc, 8'd170);
      queue_op(OpAlloc, 8'd85);
      queue_op(OpAlloc, 8'd0);
      queue_op(OpFree, 8'd0);

      // A size of zero is taken as one block, which makes the empty pool easy to reach.
      run_phase(9'd0, 0, PhaseMixed, 1'b0);
      queue_op(OpAlloc, 8'd0);
      queue_op(OpAlloc, 8'd255);
      queue_op(OpAlloc, 8'd0);
      queue_op(OpFree, 8'd1);
      queue_op(OpFree, 8'd255);
      queue_op(OpFree, 8'd0);
      queue_op(OpFree, 8'd0);
      queue_op(OpAlloc, 8'd0);
      queue_op(OpAlloc, 8'd0);
      queue_op(OpAlloc, 8'd0);

      run_phase(9'd511, 300, PhaseDrain, 1'b0);
      run_phase(9'd256, 300, PhaseFlood, 1'b0);
      run_phase(9'd1, 60, PhaseMixed, 1'b0);
      run_phase(9'd2, 100, PhaseMixed, 1'b0);
      run_phase(CountW'($urandom_range(3, 16)), 250, PhaseMixed, 1'b0);
      run_phase(9'd300, 200, PhaseMixed, 1'b1);
      run_phase(CountW'($urandom_range(1, 256)), 150, PhaseMixed, 1'b0);
      settle();

      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
